### hdl/swlrl_pkg.sv
// Shared types and constants for the sliding window log rate limiter.
// No dependencies; used by every module of the block except swlrl_ram.
`default_nettype none

package swlrl_pkg;

    // Fixed field widths
    localparam int TIME_IN_BITS   = 32;
    localparam int WINDOW_BITS    = 32;
    localparam int LIMIT_BITS     = 5;
    localparam int COUNT_OUT_BITS = 5;
    localparam int CFG_IDX_BITS   = 2;

    // Parameter defaults
    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_TIME_BITS = 32;

    // Register map
    localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TICKS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MAX_REQUESTS = 2'd1;

    // Register reset values
    localparam logic [WINDOW_BITS-1:0] WINDOW_TICKS_RESET = 32'd1000;
    localparam logic [LIMIT_BITS-1:0]  MAX_REQUESTS_RESET = 5'd2;

    // Controller states
    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture request time, start ring read
        logic pop;     // drop the oldest entry
        logic commit;  // decide, store time, load result register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic expire;  // oldest entry exists and its age reached the window
    } dp_status_t;

endpackage

`default_nettype wire

### hdl/swlrl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module swlrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      aclk,
    input  wire logic                                      wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hdl/swlrl_ctrl.sv
// Controller FSM for the rate limiter: sequences expiry pops and the decision.
// Depends on swlrl_pkg.
`default_nettype none

module swlrl_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    input  wire swlrl_pkg::dp_status_t  status,
    output swlrl_pkg::ctrl_cmd_t        cmd
);

    swlrl_pkg::state_t state_reg, state_next;
    logic              m_valid_reg, m_valid_next;
    logic              out_free;

    // Result register may be loaded when empty or being drained
    assign out_free = !m_valid_reg || m_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swlrl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = swlrl_pkg::ST_SCAN;
                end
            end
            swlrl_pkg::ST_SCAN: begin
                if (!status.expire && out_free) begin
                    state_next = swlrl_pkg::ST_IDLE;
                end
            end
            default: state_next = swlrl_pkg::ST_IDLE;
        endcase
    end

    // Outputs / commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            swlrl_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            swlrl_pkg::ST_SCAN: begin
                cmd.pop    = status.expire;
                cmd.commit = !status.expire && out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Result valid flag
    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swlrl_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

### hdl/swlrl_dp.sv
// Datapath for the rate limiter: config registers, time ring, pointers,
// age compare, admit decision and result register.
// Depends on swlrl_pkg and swlrl_ram.
`default_nettype none

module swlrl_dp #(
    parameter int DEPTH     = swlrl_pkg::DEFAULT_DEPTH,
    parameter int TIME_BITS = swlrl_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr,
    input  wire logic [swlrl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [swlrl_pkg::WINDOW_BITS-1:0]      cfg_data,
    input  wire logic [swlrl_pkg::TIME_IN_BITS-1:0]     s_request_time,
    input  wire swlrl_pkg::ctrl_cmd_t                   cmd,
    output swlrl_pkg::dp_status_t                       status,
    output logic                                        m_allowed,
    output logic      [swlrl_pkg::COUNT_OUT_BITS-1:0]   m_in_window
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam int LIM_W = (CNT_W > swlrl_pkg::LIMIT_BITS) ? CNT_W : swlrl_pkg::LIMIT_BITS;

    logic [swlrl_pkg::WINDOW_BITS-1:0]    window_reg;
    logic [swlrl_pkg::LIMIT_BITS-1:0]     max_reg;
    logic [TIME_BITS-1:0]                 now_reg;
    logic [IDX_W-1:0]                     oldest_reg, oldest_next, oldest_inc;
    logic [CNT_W-1:0]                     count_reg, count_next;
    logic                                 allowed_reg;
    logic [swlrl_pkg::COUNT_OUT_BITS-1:0] in_window_reg;

    logic [TIME_BITS-1:0] window_t;
    logic [TIME_BITS-1:0] ring_rd_data;
    logic [TIME_BITS-1:0] age;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     slot;
    logic [SUM_W-1:0]     slot_sum;
    logic [LIM_W-1:0]     limit;
    logic                 admit;
    logic                 ring_wr;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= swlrl_pkg::WINDOW_TICKS_RESET;
            max_reg    <= swlrl_pkg::MAX_REQUESTS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                swlrl_pkg::REG_WINDOW_TICKS: window_reg <= cfg_data;
                swlrl_pkg::REG_MAX_REQUESTS: max_reg <= cfg_data[swlrl_pkg::LIMIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Request time capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg <= TIME_BITS'(s_request_time);
        end
    end

    // Ring pointer arithmetic
    assign oldest_inc = (oldest_reg == IDX_W'(DEPTH - 1)) ? '0 : oldest_reg + IDX_W'(1);
    assign slot_sum   = SUM_W'(oldest_reg) + SUM_W'(count_reg);
    assign slot       = (slot_sum >= SUM_W'(DEPTH)) ? IDX_W'(slot_sum - SUM_W'(DEPTH))
                                                    : IDX_W'(slot_sum);

    // Read the entry that will be oldest next cycle
    assign rd_addr = cmd.pop ? oldest_inc : oldest_reg;

    // Expiry check on the oldest entry
    assign window_t      = TIME_BITS'(window_reg);
    assign age           = now_reg - ring_rd_data;
    assign status.expire = (count_reg != '0) && (age >= window_t);

    // Admit decision, limit clamped to ring depth
    assign limit   = (LIM_W'(max_reg) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(max_reg);
    assign admit   = LIM_W'(count_reg) < limit;
    assign ring_wr = cmd.commit && admit;

    swlrl_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (ring_wr),
        .wr_addr (slot),
        .wr_data (now_reg),
        .rd_addr (rd_addr),
        .rd_data (ring_rd_data)
    );

    // Pointer and count update
    always_comb begin
        oldest_next = oldest_reg;
        count_next  = count_reg;
        if (cmd.pop) begin
            oldest_next = oldest_inc;
            count_next  = count_reg - CNT_W'(1);
        end else if (ring_wr) begin
            count_next  = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oldest_reg <= '0;
            count_reg  <= '0;
        end else begin
            oldest_reg <= oldest_next;
            count_reg  <= count_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            allowed_reg   <= admit;
            in_window_reg <= swlrl_pkg::COUNT_OUT_BITS'(count_next);
        end
    end

    assign m_allowed   = allowed_reg;
    assign m_in_window = in_window_reg;

endmodule

`default_nettype wire

### hdl/sliding_window_log_rate_limiter.sv
// Sliding window log rate limiter, top level.
// Depends on swlrl_pkg, swlrl_ctrl, swlrl_dp (which holds swlrl_ram).
//
// Usage:
//   Input channel (s_valid/s_ready/s_request_time): one transfer per request,
//   carrying its arrival time in ticks; times are non-decreasing mod 2^32.
//   Result channel (m_valid/m_ready/m_allowed/m_in_window): one transfer per
//   request, in order: admitted flag and ring occupancy after the request.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes
//   window_ticks, index 1 writes max_requests; other indexes are ignored.
//   cfg_ready is always high; write only while no request is in flight.
//   Sequence: after the request transfer, the controller pops each entry that
//   it expires in turn, one at a time because of the single read port of the
//   time ring, then decides and stores; m_valid rises when the decision is stored.
//   s_ready rises together with m_valid, so a new request waits for the result.
//   Reset (aresetn low, synchronous) empties the ring and restores the
//   register defaults (window 1000, limit 2); ring contents are not cleared.
//   Receiver stall: the result waits in the output register while the next
//   request is taken and scanned; that one then holds s_ready low until
//   m_ready frees the output register.
`default_nettype none

module sliding_window_log_rate_limiter #(
    parameter int DEPTH     = swlrl_pkg::DEFAULT_DEPTH,
    parameter int TIME_BITS = swlrl_pkg::DEFAULT_TIME_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [swlrl_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [swlrl_pkg::WINDOW_BITS-1:0]    cfg_data,
    // requests
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic [swlrl_pkg::TIME_IN_BITS-1:0]   s_request_time,
    // results
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_allowed,
    output logic      [swlrl_pkg::COUNT_OUT_BITS-1:0] m_in_window
);

    swlrl_pkg::ctrl_cmd_t  cmd;
    swlrl_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    swlrl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    swlrl_dp #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_request_time (s_request_time),
        .cmd            (cmd),
        .status         (status),
        .m_allowed      (m_allowed),
        .m_in_window    (m_in_window)
    );

endmodule

`default_nettype wire
